@@ rtl/sss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for sample set statistics
// Sizes of the accumulators, the divider and the job queue, plus the beat
// structs of both channels and the job record between front and back.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Set size limit; all accumulator widths follow from it
    localparam int MAX_SAMPLES = 16;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 46;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES) + 1;
    localparam int SQ_W   = 2 * SAMPLE_W - 1 + $clog2(MAX_SAMPLES);
    // |sum| never exceeds 2**(SUM_W-2), so one bit less holds it
    localparam int ABS_W  = SUM_W - 1;
    localparam int PROD_W = CNT_W + SQ_W;
    localparam int SQR_W  = 2 * ABS_W;
    localparam int D_W    = (PROD_W > SQR_W) ? PROD_W : SQR_W;

    // Divider: numerator carries the Q.16 scaling, divisor is sized for n*n
    localparam int NUM_W      = D_W + FRAC_W;
    localparam int DEN_W      = 2 * CNT_W;
    localparam int DIV_STEP_W = $clog2(NUM_W + 1);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } smp_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [MEAN_W-1:0]   mean_q16;
        logic [VAR_W-1:0]           variance_q16;
        logic                       overflow;
    } res_beat_t;

    // Snapshot of one finished set
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SUM_W-1:0]    sum;
        logic [SQ_W-1:0]            sumsq;
        logic [CNT_W-1:0]           cnt;
        logic                       overflow;
    } job_t;

endpackage

@@ rtl/sss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_front: sample accumulator
// Takes one sample per cycle while not stalled, tracks max, min, sum, sum of squares and
// count, and hands a snapshot of the set to the job queue on the last beat.
// ----------------------------------------------------------------------------
module sss_front
    import sss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      smp_valid,
    input  logic      smp_stall,
    input  smp_beat_t smp_data,
    output logic      job_push,
    output job_t      job_data
);

    logic signed [SAMPLE_W-1:0]   max_reg, max_next, max_upd;
    logic signed [SAMPLE_W-1:0]   min_reg, min_next, min_upd;
    logic signed [SUM_W-1:0]      sum_reg, sum_next, sum_upd;
    logic [SQ_W-1:0]              sumsq_reg, sumsq_next, sumsq_upd;
    logic [CNT_W-1:0]             cnt_reg, cnt_next, cnt_upd;
    logic                         ovf_reg, ovf_next, ovf_upd;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic                         full;
    logic                         accept;

    assign accept = smp_valid && !smp_stall;
    assign full   = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign sq     = smp_data.sample * smp_data.sample;

    // Fold the sample in unless the set is already full
    always_comb
    begin
        max_upd   = max_reg;
        min_upd   = min_reg;
        sum_upd   = sum_reg;
        sumsq_upd = sumsq_reg;
        cnt_upd   = cnt_reg;
        ovf_upd   = ovf_reg;
        if (!full)
        begin
            if (cnt_reg == '0)
            begin
                max_upd = smp_data.sample;
                min_upd = smp_data.sample;
            end
            else
            begin
                if (smp_data.sample > max_reg)
                    max_upd = smp_data.sample;
                if (smp_data.sample < min_reg)
                    min_upd = smp_data.sample;
            end
            sum_upd   = sum_reg + SUM_W'(smp_data.sample);
            sumsq_upd = sumsq_reg + SQ_W'(sq[2*SAMPLE_W-2:0]);
            cnt_upd   = cnt_reg + CNT_W'(1);
        end
        else
        begin
            ovf_upd = 1'b1;
        end
    end

    // Snapshot goes out on the last beat, then everything clears
    always_comb
    begin
        job_push           = accept && smp_data.last;
        job_data.max_value = max_upd;
        job_data.min_value = min_upd;
        job_data.sum       = sum_upd;
        job_data.sumsq     = sumsq_upd;
        job_data.cnt       = cnt_upd;
        job_data.overflow  = ovf_upd;

        max_next   = max_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (smp_data.last)
            begin
                max_next   = '0;
                min_next   = '0;
                sum_next   = '0;
                sumsq_next = '0;
                cnt_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                max_next   = max_upd;
                min_next   = min_upd;
                sum_next   = sum_upd;
                sumsq_next = sumsq_upd;
                cnt_next   = cnt_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            min_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            max_reg   <= max_next;
            min_reg   <= min_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ rtl/sss_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_queue: job queue
// Small FIFO of finished-set snapshots between the accumulator and the
// result engine, so each side can stall on its own.
// ----------------------------------------------------------------------------
module sss_queue
    import sss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_data,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output job_t  pop_data
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/sss_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_div: restoring divider
// Unsigned radix-2 divider, one quotient bit per cycle. done pulses in the
// cycle after the last step; quotient and remainder flag stay until the
// next start.
// ----------------------------------------------------------------------------
module sss_div
    import sss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic             rem_nz
);

    logic [NUM_W-1:0]      quo_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [DEN_W:0]        trial;
    logic [DEN_W:0]        trial_sub;
    logic                  ge;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        trial_sub = ge ? (trial - {1'b0, den_reg}) : trial;
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= DIV_STEP_W'(NUM_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= trial_sub[DEN_W-1:0];
        end
    end

    assign done   = done_reg;
    assign quot   = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

@@ rtl/sss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_back: result engine
// Pops one set snapshot, forms n*sumsq - sum^2, runs the mean and variance
// divisions side by side and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module sss_back
    import sss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job_data,
    output logic      job_pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_data
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_DIFF = 6'b000100,
        B_LOAD = 6'b001000,
        B_DIV  = 6'b010000,
        B_OUT  = 6'b100000
    } back_state_t;

    back_state_t      state_reg, state_next;
    job_t             job_reg;
    logic [ABS_W-1:0] abs_reg, abs_next;
    logic             neg_reg, neg_next;
    logic [D_W-1:0]   prod_reg, prod_next;
    logic [D_W-1:0]   sqr_reg, sqr_next;
    logic [D_W-1:0]   diff;
    logic             res_valid_reg, res_valid_next;
    res_beat_t        res_data_reg, res_data_next;

    logic             div_start;
    logic [NUM_W-1:0] mean_num;
    logic [DEN_W-1:0] mean_den;
    logic [NUM_W-1:0] var_num;
    logic [DEN_W-1:0] var_den;
    logic             mean_done;
    logic             var_done;
    logic [NUM_W-1:0] mean_quot;
    logic [NUM_W-1:0] var_quot;
    logic             mean_rem_nz;
    logic             var_rem_nz;
    logic [MEAN_W:0]  mean_mag;

    // Magnitude and sign of the sum of the held job
    always_comb
    begin
        neg_next = job_reg.sum[SUM_W-1];
        abs_next = neg_next ? ABS_W'(-job_reg.sum) : ABS_W'(job_reg.sum);
    end

    // Products, registered before the subtract
    assign prod_next = D_W'(job_reg.cnt) * D_W'(job_reg.sumsq);
    assign sqr_next  = D_W'(abs_reg) * D_W'(abs_reg);
    assign diff      = (prod_reg > sqr_reg) ? (prod_reg - sqr_reg) : '0;

    // Divider operands
    assign mean_num = NUM_W'({abs_reg, {FRAC_W{1'b0}}});
    assign mean_den = DEN_W'(job_reg.cnt);
    assign var_num  = {diff, {FRAC_W{1'b0}}};
    assign var_den  = DEN_W'(job_reg.cnt) * DEN_W'(job_reg.cnt);

    // Floor rounding for a negative mean
    assign mean_mag = mean_quot[MEAN_W:0] + (MEAN_W+1)'(mean_rem_nz);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_pop        = 1'b0;
        div_start      = 1'b0;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_DIFF;
            end
            B_DIFF:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                // products are registered, both operands are ready
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (mean_done && var_done)
                begin
                    res_data_next.max_value    = job_reg.max_value;
                    res_data_next.min_value    = job_reg.min_value;
                    res_data_next.mean_q16     = neg_reg ? MEAN_W'(-mean_mag)
                                                         : mean_quot[MEAN_W-1:0];
                    res_data_next.variance_q16 = var_quot[VAR_W-1:0];
                    res_data_next.overflow     = job_reg.overflow;
                    res_valid_next             = 1'b1;
                    state_next                 = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job_data;
        if (state_reg == B_MUL)
        begin
            abs_reg  <= abs_next;
            neg_reg  <= neg_next;
        end
        if (state_reg == B_DIFF)
        begin
            prod_reg <= prod_next;
            sqr_reg  <= sqr_next;
        end
        res_data_reg <= res_data_next;
    end

    sss_div u_mean_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (mean_num),
        .den    (mean_den),
        .done   (mean_done),
        .quot   (mean_quot),
        .rem_nz (mean_rem_nz)
    );

    sss_div u_var_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (var_num),
        .den    (var_den),
        .done   (var_done),
        .quot   (var_quot),
        .rem_nz (var_rem_nz)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ rtl/sample_set_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_set_statistics: min / max / mean / variance of sample sets
// Accumulates signed samples and, on the last beat of each set, produces
// max, min, Q.16 mean and Q.16 population variance.
//
//   channel  | dir | beat        | handshake
//   ---------+-----+-------------+------------------------------
//   smp      | in  | smp_beat_t  | smp_valid / smp_stall
//   res      | out | res_beat_t  | res_valid / res_stall
//
// Samples are taken one per cycle while the job queue has room.
// The result engine finishes each set before it pops the next, its divider
// giving one quotient bit per cycle; up to two finished sets wait in
// the queue while the next set keeps streaming in.
// Reset clears all accumulators, empties the queue and clears the result valid flag.
// smp_stall rises only while the queue is full.
// ----------------------------------------------------------------------------
module sample_set_statistics
    import sss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      smp_valid,
    output logic      smp_stall,
    input  smp_beat_t smp_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_data
);

    logic job_push;
    job_t job_in;
    logic q_full;
    logic job_pop;
    logic job_valid;
    job_t job_out;

    assign smp_stall = q_full;

    sss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .job_push  (job_push),
        .job_data  (job_in)
    );

    sss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (q_full),
        .pop       (job_pop),
        .pop_valid (job_valid),
        .pop_data  (job_out)
    );

    sss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

@@ rtl/sss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_checker: port-level checks for sample_set_statistics
// Watches both channels for handshake stability and the result channel
// for results that cannot come from any set of samples.
// ----------------------------------------------------------------------------
module sss_checker
    import sss_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      smp_valid,
    input logic      smp_stall,
    input smp_beat_t smp_data,
    input logic      res_valid,
    input logic      res_stall,
    input res_beat_t res_data
);

    // A stalled sample beat holds
    a_smp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_stall |=> smp_valid && $stable(smp_data))
        else $error("sample beat changed while stalled");

    // A stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // Max never below min
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.max_value >= res_data.min_value))
        else $error("max below min");

    // Mean lies between min and max
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ($signed(res_data.mean_q16) >= $signed({res_data.min_value, 16'h0000}))
                   && ($signed(res_data.mean_q16) <= $signed({res_data.max_value, 16'h0000})))
        else $error("mean outside min/max");

    // A constant set has no spread
    a_flat_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.max_value == res_data.min_value)
            |-> (res_data.variance_q16 == '0)
             && (res_data.mean_q16 == {res_data.max_value, 16'h0000}))
        else $error("constant set with nonzero variance or wrong mean");

endmodule

bind sample_set_statistics sss_checker u_sss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_data  (smp_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
